@@ hdl/bellman_ford_shortest_paths_core_assert.svh @@
`ifndef BELLMAN_FORD_SHORTEST_PATHS_CORE_ASSERT_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BFSP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BFSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/bfsp_pkg.sv @@
package bfsp_pkg;

   localparam logic [1:0] REQ_LOAD_OFFSET = 2'd0;
   localparam logic [1:0] REQ_LOAD_EDGE   = 2'd1;
   localparam logic [1:0] REQ_RUN         = 2'd2;
   localparam logic [1:0] REQ_READ        = 2'd3;

   localparam logic CSR_VERTEX_COUNT = 1'b0;
   localparam logic CSR_EDGE_COUNT   = 1'b1;

   localparam logic signed [47:0] DIST_MAX = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] DIST_MIN = {1'b1, {47{1'b0}}};

   typedef struct packed {
      logic [1:0]         req_type;
      logic [12:0]        slot_index;
      logic [13:0]        offset_value;
      logic [9:0]         edge_target;
      logic signed [31:0] weight_q16;
      logic [9:0]         source_vertex;
   } req_item_type;

   typedef struct packed {
      logic [9:0]         vertex_id;
      logic               reached;
      logic [9:0]         predecessor;
      logic signed [47:0] distance;
   } rsp_item_type;

   // One entry of the per-vertex result memory.
   typedef struct packed {
      logic               reached;
      logic [9:0]         pred;
      logic signed [47:0] path_dist;
   } state_word_type;

   // One entry of the edge memory.
   typedef struct packed {
      logic [9:0]         target;
      logic signed [31:0] weight;
   } edge_word_type;

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_SRC    = 8'b0000_0100,
      ST_V_RD   = 8'b0000_1000,
      ST_V_CHK  = 8'b0001_0000,
      ST_E_RD   = 8'b0010_0000,
      ST_E_WAIT = 8'b0100_0000,
      ST_E_UPD  = 8'b1000_0000
   } fsm_state_type;

endpackage

@@ hdl/bellman_ford_shortest_paths_core.sv @@
// Channel  | Direction | Handshake            | Payload
// req      | in        | req_valid/req_stall  | req_data  (req_item_type)
// rsp      | out       | rsp_valid/rsp_stall  | rsp_data  (rsp_item_type)
// csr      | in        | csr_wr_en            | csr_index, csr_wr_data
//
// A load is written to its memory on acceptance; a read is answered through the state
// memory and the output register, and holds off the next transaction until its answer is out.
// A run clears the whole state memory and seeds the source; then, over vertex_count
// passes, it visits each vertex (ST_V_RD, ST_V_CHK) and, for a reached vertex, reads
// each edge (ST_E_RD, ST_E_WAIT) and relaxes its target (ST_E_UPD) unless absent.
// Reset starts the same sweep and takes only csr writes; a stalled result blocks input.
`include "bellman_ford_shortest_paths_core_assert.svh"

module bellman_ford_shortest_paths_core
   import bfsp_pkg::*;
#(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_EDGES    = 8192
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic         csr_index,
   input  logic [13:0]  csr_wr_data,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

   // Configuration registers.
   logic [10:0] vcount_ff, vcount_in;
   logic [13:0] ecount_ff, ecount_in;

   // Sequencer state.
   fsm_state_type st_ff, st_in;
   logic          run_ff, run_in;           // the clearing sweep belongs to a run
   logic [VW-1:0] clr_ff, clr_in;
   logic [9:0]    src_ff, src_in;
   logic [VW-1:0] pass_ff, pass_in;
   logic [VW-1:0] u_ff, u_in;
   logic [EW:0]   e_ff, e_in;
   logic [EW:0]   last_ff, last_in;
   logic signed [47:0] du_ff, du_in;
   logic [9:0]    v_ff, v_in;
   logic          rd_pend_ff, rd_pend_in;
   logic [9:0]    rd_id_ff, rd_id_in;

   // Output register.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic           off_wr_en;
   logic [13:0]    off_rd_a, off_rd_b;
   logic           edge_wr_en;
   edge_word_type  edge_wr_data, edge_q;
   logic           st_wr_en;
   logic [VW-1:0]  st_wr_addr, st_rd_addr;
   state_word_type st_wr_data, st_q;

   // Derived run limits.
   logic [VW:0]   nv;
   logic [EW:0]   ne;
   logic [EW:0]   last_cand;
   logic          u_has_next;
   logic          req_fire;
   logic          rsp_free;
   logic signed [48:0] sum_wide;
   logic signed [47:0] nd;
   logic          better;

   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   // Loads and reads are taken only when idle, with no read in flight and the
   // output register able to take a new result.
   assign req_stall = (st_ff != ST_IDLE) || rd_pend_ff || !rsp_free;

   assign nv = (32'(vcount_ff) < 32'(MAX_VERTICES)) ? (VW+1)'(vcount_ff)
                                                     : (VW+1)'(MAX_VERTICES);
   assign ne = (32'(ecount_ff) < 32'(MAX_EDGES)) ? (EW+1)'(ecount_ff)
                                                  : (EW+1)'(MAX_EDGES);
   assign u_has_next = (32'(u_ff) + 32'd1) < 32'(nv);

   // End of the current vertex's list: the next vertex's start, or the edge
   // count for the last vertex, never above the edge memory size.
   always_comb begin
      if (!u_has_next) begin
         last_cand = ne;
      end else if (32'(off_rd_b) > 32'(MAX_EDGES)) begin
         last_cand = (EW+1)'(MAX_EDGES);
      end else begin
         last_cand = (EW+1)'(off_rd_b);
      end
   end

   // Saturating relaxation: the sum is clamped to the 48-bit range before the
   // strict comparison with the stored distance.
   assign sum_wide = 49'(du_ff) + 49'(edge_q.weight);
   always_comb begin
      if (sum_wide > 49'(DIST_MAX)) begin
         nd = DIST_MAX;
      end else if (sum_wide < 49'(DIST_MIN)) begin
         nd = DIST_MIN;
      end else begin
         nd = sum_wide[47:0];
      end
   end
   assign better = !st_q.reached || (nd < st_q.path_dist);

   // Graph loads.
   assign off_wr_en  = req_fire && (req_data.req_type == REQ_LOAD_OFFSET)
                       && (32'(req_data.slot_index) < 32'(MAX_VERTICES));
   assign edge_wr_en = req_fire && (req_data.req_type == REQ_LOAD_EDGE)
                       && (32'(req_data.slot_index) < 32'(MAX_EDGES));
   assign edge_wr_data = {req_data.edge_target, req_data.weight_q16};

   always_comb begin
      vcount_in = vcount_ff;
      ecount_in = ecount_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_VERTEX_COUNT: vcount_in = csr_wr_data[10:0];
            CSR_EDGE_COUNT:   ecount_in = csr_wr_data;
            default:          vcount_in = vcount_ff;
         endcase
      end
   end

   // Main sequencer. Each edge is handled to completion before the next one
   // is read, so the only overlap is an edge that improves its own source
   // vertex; the held source distance is refreshed in that case.
   always_comb begin
      st_in      = st_ff;
      run_in     = run_ff;
      clr_in     = clr_ff;
      src_in     = src_ff;
      pass_in    = pass_ff;
      u_in       = u_ff;
      e_in       = e_ff;
      last_in    = last_ff;
      du_in      = du_ff;
      v_in       = v_ff;
      rd_pend_in = 1'b0;
      rd_id_in   = rd_id_ff;
      st_wr_en   = 1'b0;
      st_wr_addr = clr_ff;
      st_wr_data = '0;
      st_rd_addr = u_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (rd_pend_ff) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.vertex_id = rd_id_ff;
         rsp_data_in.reached   = st_q.reached;
         rsp_data_in.predecessor = st_q.reached ? st_q.pred : 10'd0;
         rsp_data_in.distance  = st_q.reached ? st_q.path_dist : 48'sd0;
      end

      case (st_ff)
         ST_CLEAR: begin
            st_wr_en   = 1'b1;
            st_wr_addr = clr_ff;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == VW'(MAX_VERTICES - 1)) begin
               clr_in = '0;
               st_in  = run_ff ? ST_SRC : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_data.req_type)
                  REQ_RUN: begin
                     run_in = 1'b1;
                     src_in = req_data.source_vertex;
                     st_in  = ST_CLEAR;
                  end
                  REQ_READ: begin
                     st_rd_addr = VW'(req_data.slot_index);
                     rd_id_in   = req_data.slot_index[9:0];
                     rd_pend_in = 32'(req_data.slot_index) < 32'(MAX_VERTICES);
                  end
                  default: begin
                     st_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SRC: begin
            run_in  = 1'b0;
            pass_in = '0;
            u_in    = '0;
            if (32'(src_ff) < 32'(nv)) begin
               st_wr_en             = 1'b1;
               st_wr_addr           = VW'(src_ff);
               st_wr_data.reached   = 1'b1;
               st_wr_data.pred      = src_ff;
               st_wr_data.path_dist = 48'sd0;
               st_in                = ST_V_RD;
            end else begin
               st_in = ST_IDLE;
            end
         end
         ST_V_RD: begin
            st_rd_addr = u_ff;
            st_in      = ST_V_CHK;
         end
         ST_V_CHK: begin
            e_in    = (EW+1)'(off_rd_a);
            last_in = last_cand;
            du_in   = st_q.path_dist;
            if (st_q.reached && (32'(off_rd_a) < 32'(last_cand))) begin
               st_in = ST_E_RD;
            end else begin
               st_in = ST_V_RD;
               u_in  = u_ff + 1'b1;
               if (!u_has_next) begin
                  u_in    = '0;
                  pass_in = pass_ff + 1'b1;
                  if ((32'(pass_ff) + 32'd1) >= 32'(nv)) begin
                     st_in = ST_IDLE;
                  end
               end
            end
         end
         ST_E_RD: begin
            st_in = ST_E_WAIT;
         end
         ST_E_WAIT: begin
            v_in       = edge_q.target;
            st_rd_addr = VW'(edge_q.target);
            if (32'(edge_q.target) < 32'(nv)) begin
               st_in = ST_E_UPD;
            end else begin
               e_in  = e_ff + 1'b1;
               st_in = ((e_ff + 1'b1) < last_ff) ? ST_E_RD : ST_V_RD;
               if ((e_ff + 1'b1) >= last_ff) begin
                  u_in = u_ff + 1'b1;
                  if (!u_has_next) begin
                     u_in    = '0;
                     pass_in = pass_ff + 1'b1;
                     if ((32'(pass_ff) + 32'd1) >= 32'(nv)) begin
                        st_in = ST_IDLE;
                     end
                  end
               end
            end
         end
         ST_E_UPD: begin
            if (better) begin
               st_wr_en             = 1'b1;
               st_wr_addr           = VW'(v_ff);
               st_wr_data.reached   = 1'b1;
               st_wr_data.pred      = 10'(u_ff);
               st_wr_data.path_dist = nd;
               if (32'(v_ff) == 32'(u_ff)) begin
                  du_in = nd;
               end
            end
            e_in  = e_ff + 1'b1;
            st_in = ((e_ff + 1'b1) < last_ff) ? ST_E_RD : ST_V_RD;
            if ((e_ff + 1'b1) >= last_ff) begin
               u_in = u_ff + 1'b1;
               if (!u_has_next) begin
                  u_in    = '0;
                  pass_in = pass_ff + 1'b1;
                  if ((32'(pass_ff) + 32'd1) >= 32'(nv)) begin
                     st_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= 11'd1;
         ecount_ff    <= 14'd0;
         st_ff        <= ST_CLEAR;
         run_ff       <= 1'b0;
         clr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vcount_ff    <= vcount_in;
         ecount_ff    <= ecount_in;
         st_ff        <= st_in;
         run_ff       <= run_in;
         clr_ff       <= clr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      pass_ff     <= pass_in;
      u_ff        <= u_in;
      e_ff        <= e_in;
      last_ff     <= last_in;
      du_ff       <= du_in;
      v_ff        <= v_in;
      rd_id_ff    <= rd_id_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   bfsp_graph_mem #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_graph_mem (
      .clock         (clock),
      .off_wr_en     (off_wr_en),
      .off_wr_addr   (VW'(req_data.slot_index)),
      .off_wr_data   (req_data.offset_value),
      .off_rd_addr_a (u_ff),
      .off_rd_addr_b (VW'(u_ff + 1'b1)),
      .off_rd_data_a (off_rd_a),
      .off_rd_data_b (off_rd_b),
      .edge_wr_en    (edge_wr_en),
      .edge_wr_addr  (EW'(req_data.slot_index)),
      .edge_wr_data  (edge_wr_data),
      .edge_rd_addr  (e_ff[EW-1:0]),
      .edge_rd_data  (edge_q)
   );

   bfsp_state_mem #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_state_mem (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_q)
   );

   `BFSP_ASSERT_NOW(a_accept_idle, req_fire, st_ff == ST_IDLE, "transaction accepted while busy")
   `BFSP_ASSERT_NOW(a_read_slot_free, rd_pend_ff, !rsp_valid_ff, "read data with output full")
   `BFSP_ASSERT_NOW(a_edge_in_range, st_ff == ST_E_RD, e_ff < last_ff, "edge index past list end")
   `BFSP_ASSERT_NOW(a_relax_target, st_ff == ST_E_UPD && st_wr_en, 32'(v_ff) < 32'(nv),
                    "relaxed vertex beyond vertex count")
   `BFSP_ASSERT_NEXT(a_run_clears, req_fire && req_data.req_type == REQ_RUN, st_ff == ST_CLEAR,
                     "run did not start with a clearing sweep")

endmodule

@@ hdl/bfsp_graph_mem.sv @@
module bfsp_graph_mem
   import bfsp_pkg::*;
#(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_EDGES    = 8192,
   localparam int VW = $clog2(MAX_VERTICES),
   localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
   input  logic          clock,
   input  logic          off_wr_en,
   input  logic [VW-1:0] off_wr_addr,
   input  logic [13:0]   off_wr_data,
   input  logic [VW-1:0] off_rd_addr_a,
   input  logic [VW-1:0] off_rd_addr_b,
   output logic [13:0]   off_rd_data_a,
   output logic [13:0]   off_rd_data_b,
   input  logic          edge_wr_en,
   input  logic [EW-1:0] edge_wr_addr,
   input  edge_word_type edge_wr_data,
   input  logic [EW-1:0] edge_rd_addr,
   output edge_word_type edge_rd_data
);

   logic [13:0]   offset_mem [MAX_VERTICES];
   edge_word_type edge_mem   [MAX_EDGES];

   // The offset memory has two read ports: a vertex needs its own start and
   // the start of the next vertex.
   always_ff @(posedge clock) begin
      if (off_wr_en) begin
         offset_mem[off_wr_addr] <= off_wr_data;
      end
      off_rd_data_a <= offset_mem[off_rd_addr_a];
      off_rd_data_b <= offset_mem[off_rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (edge_wr_en) begin
         edge_mem[edge_wr_addr] <= edge_wr_data;
      end
      edge_rd_data <= edge_mem[edge_rd_addr];
   end

endmodule

@@ hdl/bfsp_state_mem.sv @@
module bfsp_state_mem
   import bfsp_pkg::*;
#(
   parameter int MAX_VERTICES = 1024,
   localparam int VW = $clog2(MAX_VERTICES)
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [VW-1:0]  wr_addr,
   input  state_word_type wr_data,
   input  logic [VW-1:0]  rd_addr,
   output state_word_type rd_data
);

   state_word_type state_mem [MAX_VERTICES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[wr_addr] <= wr_data;
      end
      rd_data <= state_mem[rd_addr];
   end

endmodule

@@ test/bellman_ford_shortest_paths_core_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the shortest path core. Every accepted request
// transaction is also applied to a behavioral copy of the graph and the
// per-vertex result state. Read transactions push the response they must
// produce onto a queue, and a monitor compares each accepted response
// transaction with the oldest queue entry, field by field.
module bellman_ford_shortest_paths_core_tb;
   import bfsp_pkg::*;

   localparam int NV_LIMIT = 1024;
   localparam int NE_LIMIT = 8192;
   localparam longint DIST_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint DIST_LO = -DIST_HI - 1;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_wr_en = 1'b0;
   logic         csr_index = CSR_VERTEX_COUNT;
   logic [13:0]  csr_wr_data = '0;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   // When set, neither side inserts idle or stall cycles.
   bit quiet = 1'b0;
   int error_count = 0;

   // Mirror of the graph memories, the register file and the result state.
   logic [13:0]        offset_mem [NV_LIMIT];
   logic [9:0]         target_mem [NE_LIMIT];
   logic signed [31:0] weight_mem [NE_LIMIT];
   longint             dist_mem   [NV_LIMIT];
   logic [9:0]         pred_mem   [NV_LIMIT];
   bit                 reached_mem[NV_LIMIT];
   int unsigned        vertex_count_reg = 1;
   int unsigned        edge_count_reg = 0;

   // Responses that read transactions have made due, oldest first.
   rsp_item_type pending_reads[$];

   bellman_ford_shortest_paths_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A generous bound on the whole run; the slowest correct run is far below it.
   initial begin
      #50ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // The response side stalls in short random bursts until the quiet tail.
   initial begin
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic flag_mismatch(input string what);
      error_count++;
      $display("%0t: mismatch: %s", $realtime, what);
   endtask

   // Adds a path weight and an edge weight, clamped to the 48-bit range.
   function automatic longint clamp_sum(input longint a, input longint b);
      longint s;
      s = a + b;
      if (s > DIST_HI) return DIST_HI;
      if (s < DIST_LO) return DIST_LO;
      return s;
   endfunction

   // Full Bellman-Ford sweep from one source over the mirrored graph.
   task automatic solve_paths(input int unsigned src);
      int unsigned nv, ne, pass, u, e, first, last, v;
      longint nd;
      nv = (vertex_count_reg < NV_LIMIT) ? vertex_count_reg : NV_LIMIT;
      ne = (edge_count_reg < NE_LIMIT) ? edge_count_reg : NE_LIMIT;
      for (int i = 0; i < NV_LIMIT; i++) reached_mem[i] = 1'b0;
      if (src >= nv) return;
      reached_mem[src] = 1'b1;
      dist_mem[src] = '0;
      pred_mem[src] = src[9:0];
      for (pass = 0; pass < nv; pass++) begin
         for (u = 0; u < nv; u++) begin
            first = 32'(offset_mem[u]);
            last = (u + 1 < nv) ? 32'(offset_mem[u + 1]) : ne;
            if (last > NE_LIMIT) last = NE_LIMIT;
            if (!reached_mem[u]) continue;
            for (e = first; e < last; e++) begin
               v = 32'(target_mem[e]);
               if (v >= nv) continue;
               nd = clamp_sum(dist_mem[u], longint'(weight_mem[e]));
               if (!reached_mem[v] || nd < dist_mem[v]) begin
                  reached_mem[v] = 1'b1;
                  dist_mem[v] = nd;
                  pred_mem[v] = u[9:0];
               end
            end
         end
      end
   endtask

   // Applies one accepted request transaction to the mirror.
   task automatic apply_request(input req_item_type it);
      rsp_item_type r;
      case (it.req_type)
         REQ_LOAD_OFFSET: begin
            if (it.slot_index < NV_LIMIT) offset_mem[it.slot_index] = it.offset_value;
         end
         REQ_LOAD_EDGE: begin
            if (it.slot_index < NE_LIMIT) begin
               target_mem[it.slot_index] = it.edge_target;
               weight_mem[it.slot_index] = it.weight_q16;
            end
         end
         REQ_RUN: solve_paths(32'(it.source_vertex));
         REQ_READ: begin
            if (it.slot_index < NV_LIMIT) begin
               r = '0;
               r.vertex_id = it.slot_index[9:0];
               if (reached_mem[it.slot_index]) begin
                  r.reached = 1'b1;
                  r.predecessor = pred_mem[it.slot_index];
                  r.distance = dist_mem[it.slot_index][47:0];
               end
               pending_reads = {pending_reads, r};
            end
         end
         default: begin
         end
      endcase
   endtask

   // Response monitor.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reads.size() == 0) begin
            flag_mismatch($sformatf("unexpected response for vertex %0d", rsp_data.vertex_id));
         end else begin
            want = pending_reads.pop_front();
            if (rsp_data.vertex_id !== want.vertex_id)
               flag_mismatch($sformatf("vertex_id %0d, want %0d",
                  rsp_data.vertex_id, want.vertex_id));
            if (rsp_data.reached !== want.reached)
               flag_mismatch($sformatf("vertex %0d reached %0b, want %0b",
                  want.vertex_id, rsp_data.reached, want.reached));
            if (rsp_data.predecessor !== want.predecessor)
               flag_mismatch($sformatf("vertex %0d predecessor %0d, want %0d",
                  want.vertex_id, rsp_data.predecessor, want.predecessor));
            if (rsp_data.distance !== want.distance)
               flag_mismatch($sformatf("vertex %0d distance %0d, want %0d",
                  want.vertex_id, rsp_data.distance, want.distance));
         end
      end
   end

   // Builds a request with random filler in the fields its kind does not use.
   function automatic req_item_type make_request(input logic [1:0] kind,
                                                 input int unsigned slot);
      req_item_type it;
      it.req_type      = kind;
      it.slot_index    = slot[12:0];
      it.offset_value  = 14'($urandom);
      it.edge_target   = 10'($urandom);
      it.weight_q16    = $urandom;
      it.source_vertex = 10'($urandom);
      return it;
   endfunction

   // Drives one request transaction and waits until it is accepted. Valid is
   // left high, so back-to-back calls stream without a gap unless a random gap is drawn; whoever stops
   // sending lowers it at the next falling edge.
   task automatic send_request(input req_item_type it);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 2)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= it;
      // Stall is settled well before the rising edge.
      #4;
      while (req_stall) begin
         @(negedge clock);
         #4;
      end
      @(posedge clock);
      apply_request(it);
   endtask

   task automatic read_vertex(input int unsigned v);
      send_request(make_request(REQ_READ, v));
   endtask

   task automatic run_from(input int unsigned src);
      req_item_type it;
      it = make_request(REQ_RUN, $urandom);
      it.source_vertex = src[9:0];
      send_request(it);
   endtask

   task automatic load_offset(input int unsigned v, input int unsigned first);
      req_item_type it;
      it = make_request(REQ_LOAD_OFFSET, v);
      it.offset_value = first[13:0];
      send_request(it);
   endtask

   task automatic load_edge(input int unsigned slot, input int unsigned dst,
                            input logic signed [31:0] w);
      req_item_type it;
      it = make_request(REQ_LOAD_EDGE, slot);
      it.edge_target = dst[9:0];
      it.weight_q16 = w;
      send_request(it);
   endtask

   // A read cannot be served while a run is still sweeping, so once its
   // response is back the core is idle and registers may be written.
   task automatic settle();
      read_vertex(0);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input int unsigned value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value[13:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_VERTEX_COUNT) vertex_count_reg = value & 32'h7FF;
      else edge_count_reg = value & 32'h3FFF;
   endtask

   task automatic set_graph_size(input int unsigned nv, input int unsigned ne);
      write_csr(CSR_VERTEX_COUNT, nv);
      write_csr(CSR_EDGE_COUNT, ne);
   endtask

   // Before any run every vertex reads unreached; reads past the vertex
   // memory give no response at all.
   task automatic test_reads_after_reset();
      read_vertex(0);
      read_vertex(NV_LIMIT - 1);
      read_vertex(NV_LIMIT);
      read_vertex(NE_LIMIT - 1);
      settle();
   endtask

   // Small hand-made graph: extreme weights, an edge to an absent vertex, an
   // empty list whose start lies past its end, ignored loads, and a run from
   // a source outside the vertex count.
   task automatic test_small_graph();
      set_graph_size(4, 6);
      load_offset(0, 0);
      load_offset(1, 3);
      load_offset(2, 2);
      load_offset(3, 4);
      load_edge(0, 1, 32'sh7FFF_FFFF);
      load_edge(1, 2, -32'sh8000_0000);
      load_edge(2, 3, 32'sh0001_0000);
      load_edge(3, 1023, 32'sh0000_0001);
      load_edge(4, 1, -32'sh0000_0001);
      load_edge(5, 0, 32'sh0000_0000);
      load_offset(NV_LIMIT, 14'h3FFF);
      load_offset(NE_LIMIT - 1, 14'h2AAA);
      run_from(0);
      for (int v = 0; v < 4; v++) read_vertex(v);
      read_vertex(4);
      run_from(4);
      read_vertex(0);
      read_vertex(1);
      settle();
      // Single vertex with a self loop, the register's reset-like setting.
      set_graph_size(1, 1);
      load_offset(0, 0);
      load_edge(0, 0, -32'sh0000_0100);
      run_from(0);
      read_vertex(0);
      settle();
      // No vertices: a run only clears the reached flags.
      set_graph_size(0, 1);
      run_from(0);
      read_vertex(0);
      settle();
   endtask

   // Widest register settings, exercised with loads and reads only, since a full run at this
   // size would make NV_LIMIT passes over the whole graph.
   task automatic test_full_size_registers();
      set_graph_size(NV_LIMIT, NE_LIMIT);
      load_offset(NV_LIMIT - 1, NE_LIMIT);
      load_edge(NE_LIMIT - 1, 1023, 32'sh5555_AAAA);
      load_edge(NE_LIMIT - 2, 0, 32'shAAAA_5555);
      read_vertex(NV_LIMIT - 1);
      read_vertex(NV_LIMIT - 512);
      settle();
   endtask

   // A long chain of strongly negative self loops drives the distance of the
   // source past the lower 48-bit limit, where it must clamp.
   task automatic test_saturation();
      set_graph_size(160, 512);
      load_offset(0, 0);
      for (int v = 1; v < 160; v++) load_offset(v, 512);
      for (int e = 0; e < 511; e++) load_edge(e, 0, -32'sh8000_0000);
      load_edge(511, 1, 32'sh7FFF_FFFF);
      run_from(0);
      read_vertex(0);
      read_vertex(1);
      read_vertex(2);
      settle();
   endtask

   // One random graph: size, offsets, edges, a run and reads.
   task automatic random_graph();
      int unsigned nv, ne, src;
      int unsigned firsts[$];
      logic signed [31:0] w;
      nv = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(2, 12);
      ne = $urandom_range(0, 24);
      set_graph_size(nv, ne);
      for (int v = 0; v < nv; v++) firsts = {firsts, $urandom_range(0, ne)};
      // Mostly well-formed lists; sometimes left unsorted for empty lists.
      if ($urandom_range(0, 4) != 0) firsts.sort();
      for (int v = 0; v < nv; v++) load_offset(v, firsts[v]);
      for (int e = 0; e < ne; e++) begin
         w = ($urandom_range(0, 2) == 0) ? $urandom
                                         : $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh1_0000;
         load_edge(e, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, nv - 1), w);
         // Occasional load to a vertex slot past the memory; it is ignored.
         if ($urandom_range(0, 9) == 0)
            load_offset($urandom_range(NV_LIMIT, NE_LIMIT - 1), $urandom_range(0, 16383));
      end
      src = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, nv - 1);
      run_from(src);
      for (int v = 0; v < nv; v++) read_vertex(v);
      repeat ($urandom_range(1, 4)) read_vertex($urandom_range(0, NE_LIMIT - 1));
      settle();
   endtask

   task automatic test_random_graphs();
      repeat (34) random_graph();
   endtask

   task automatic test_quiet_tail();
      quiet = 1'b1;
      repeat (6) random_graph();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reads_after_reset();
      test_small_graph();
      test_full_size_registers();
      test_saturation();
      test_random_graphs();
      test_quiet_tail();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/bfsp_pkg.sv
hdl/bfsp_graph_mem.sv
hdl/bfsp_state_mem.sv
hdl/bellman_ford_shortest_paths_core.sv
test/bellman_ford_shortest_paths_core_tb.sv
